// File: hw/rtl/double_ended_queue_assert.svh
// assertion macros shared by the deque checker
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, held off while reset is asserted
`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication, held off while reset is asserted
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// File: hw/rtl/dq_pkg.sv
// deque package: field widths, operation and status codes, controller states
package dq_pkg;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_LIST       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

endpackage

// File: hw/rtl/double_ended_queue.sv
// bounded double-ended queue of signed 32-bit values in a ring buffer memory
//
// Holds up to DEPTH values in one single-port-read, single-port-write memory
// addressed by a front index and an entry count. Insert and remove
// transactions each give one status result (ok, empty or full). The result
// shows on the output the cycle after acceptance. Unused action codes are
// taken and give nothing. A list transaction on N held entries keeps the
// input closed until its last entry has gone to the output, with one memory
// read per cycle while the output register is free. The first entry passes
// through the memory read register and then the output register; output
// stalls hold it back. An empty list gives one empty result. No input is
// taken while a list is streaming. The output register lets a new
// transaction enter in the same cycle the previous result is taken.
module double_ended_queue #(
    parameter int DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic signed [dq_pkg::VALUE_W-1:0]  s_axis_tdata,  // value
    input  logic [dq_pkg::ACTION_W-1:0]   s_axis_tuser,       // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic signed [dq_pkg::VALUE_W-1:0]  m_axis_tdata,  // item
    output logic [dq_pkg::STATUS_W-1:0]   m_axis_tuser,       // status
    output logic                          m_axis_tlast
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    logic [dq_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [dq_pkg::VALUE_W-1:0] rd_data_reg;

    dq_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] remain_reg, remain_next;

    logic                         out_valid_reg, out_valid_next;
    logic [dq_pkg::VALUE_W-1:0]   out_item_reg, out_item_next;
    logic [dq_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic                         out_last_reg, out_last_next;

    logic             out_free;
    logic             accept;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] ptr_inc;
    logic [SUM_W-1:0] back_sum;
    logic [IDX_W-1:0] back_pos;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == dq_pkg::ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_item_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // ring arithmetic, one compare each
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign ptr_inc   = (ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(occ_reg);
    assign back_pos  = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                   : IDX_W'(back_sum);

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        occ_next        = occ_reg;
        ptr_next        = ptr_reg;
        remain_next     = remain_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_item_next   = out_item_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = back_pos;
        mem_re          = 1'b0;
        mem_raddr       = ptr_reg;

        unique case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_axis_tuser)
                        dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            out_item_next  = '0;
                            out_last_next  = 1'b1;
                            if (occ_reg == CNT_W'(DEPTH))
                            begin
                                out_status_next = dq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                out_status_next = dq_pkg::STATUS_OK;
                                mem_we          = 1'b1;
                                occ_next        = occ_reg + 1'b1;
                                if (s_axis_tuser == dq_pkg::ACT_PUSH_FRONT)
                                begin
                                    front_next = front_dec;
                                    mem_waddr  = front_dec;
                                end
                            end
                        end
                        dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK:
                        begin
                            out_valid_next = 1'b1;
                            out_item_next  = '0;
                            out_last_next  = 1'b1;
                            if (occ_reg == '0)
                            begin
                                out_status_next = dq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                out_status_next = dq_pkg::STATUS_OK;
                                occ_next        = occ_reg - 1'b1;
                                if (s_axis_tuser == dq_pkg::ACT_POP_FRONT)
                                begin
                                    front_next = front_inc;
                                end
                            end
                        end
                        dq_pkg::ACT_LIST:
                        begin
                            if (occ_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_item_next   = '0;
                                out_status_next = dq_pkg::STATUS_EMPTY;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                // fetch the front entry, data lands next cycle
                                mem_re      = 1'b1;
                                mem_raddr   = front_reg;
                                ptr_next    = front_inc;
                                remain_next = IDX_W'(occ_reg - 1'b1);
                                state_next  = dq_pkg::ST_LIST;
                            end
                        end
                        default:
                        begin
                            // unused action codes are dropped
                        end
                    endcase
                end
            end
            dq_pkg::ST_LIST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_item_next   = rd_data_reg;
                    out_status_next = dq_pkg::STATUS_OK;
                    out_last_next   = (remain_reg == '0);
                    if (remain_reg == '0)
                    begin
                        state_next = dq_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // read the next entry while this one goes out
                        mem_re      = 1'b1;
                        mem_raddr   = ptr_reg;
                        ptr_next    = ptr_inc;
                        remain_next = remain_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = dq_pkg::ST_IDLE;
            end
        endcase
    end

    // ring buffer storage, read data held until the next read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= s_axis_tdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dq_pkg::ST_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            ptr_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            ptr_reg       <= ptr_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg   <= out_item_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// File: hw/rtl/dq_checker.sv
// port-level checks for the deque, bound to the top level
`include "double_ended_queue_assert.svh"

module dq_port_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [dq_pkg::VALUE_W-1:0]    m_axis_tdata,
    input logic [dq_pkg::STATUS_W-1:0]   m_axis_tuser,
    input logic                          m_axis_tlast
);

    logic stalled;
    logic status_only;
    logic mid_list;

    assign stalled     = m_axis_tvalid && !m_axis_tready;
    assign status_only = m_axis_tvalid && (m_axis_tuser != dq_pkg::STATUS_OK);
    assign mid_list    = m_axis_tvalid && !m_axis_tlast;

    // a stalled result transaction keeps its payload
    `DQ_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // empty and full results carry a zero item and end their transaction
    `DQ_ASSERT_NOW(a_status_zero, clk, rst_n, status_only, (m_axis_tdata == '0) && m_axis_tlast)

    // listed entries before the final one report ok
    `DQ_ASSERT_NOW(a_list_ok, clk, rst_n, mid_list, m_axis_tuser == dq_pkg::STATUS_OK)

    // no new transaction is taken while a list is still streaming
    `DQ_ASSERT_NOW(a_list_blocks, clk, rst_n, mid_list, !s_axis_tready)

endmodule

bind double_ended_queue dq_port_checker u_dq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: sim/dq_checker.sv
// deque checker: tracks expected results for accepted transactions and compares outputs
module dq_checker
    import dq_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic signed [VALUE_W-1:0]  s_axis_tdata,   // value
    input  logic [ACTION_W-1:0]        s_axis_tuser,   // action
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic signed [VALUE_W-1:0]  m_axis_tdata,   // item
    input  logic [STATUS_W-1:0]        m_axis_tuser,   // status
    input  logic                       m_axis_tlast,
    output int                         errors,
    output int                         pending
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] item;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } deque_result_t;

    deque_result_t             awaited_results[$];
    logic signed [VALUE_W-1:0] ring_store [DEPTH];
    int                        front_pos;
    int                        held;

    task automatic apply_deque_op(input logic [ACTION_W-1:0] action,
                                  input logic signed [VALUE_W-1:0] value);
        int i;
        case (action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (held >= DEPTH)
                begin
                    awaited_results.push_back('{32'sd0, STATUS_FULL, 1'b1});
                end
                else
                begin
                    if (action == ACT_PUSH_FRONT)
                    begin
                        front_pos = (front_pos + DEPTH - 1) % DEPTH;
                        ring_store[front_pos] = value;
                    end
                    else
                    begin
                        ring_store[(front_pos + held) % DEPTH] = value;
                    end
                    held++;
                    awaited_results.push_back('{32'sd0, STATUS_OK, 1'b1});
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (held == 0)
                begin
                    awaited_results.push_back('{32'sd0, STATUS_EMPTY, 1'b1});
                end
                else
                begin
                    if (action == ACT_POP_FRONT)
                        front_pos = (front_pos + 1) % DEPTH;
                    held--;
                    awaited_results.push_back('{32'sd0, STATUS_OK, 1'b1});
                end
            end
            ACT_LIST:
            begin
                if (held == 0)
                begin
                    awaited_results.push_back('{32'sd0, STATUS_EMPTY, 1'b1});
                end
                else
                begin
                    for (i = 0; i < held; i++)
                        awaited_results.push_back('{ring_store[(front_pos + i) % DEPTH],
                                                    STATUS_OK, (i == held - 1)});
                end
            end
            default:
            begin
                // unused codes are swallowed with no result
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t exp_res;
        if (!rst_n)
        begin
            front_pos = 0;
            held      = 0;
            errors    = 0;
            awaited_results.delete();
            pending <= 0;
        end
        else
        begin
            // outputs are checked before the new transaction is predicted
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result item %0d status %0d last %0d", $time,
                             $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast);
                    errors++;
                end
                else
                begin
                    exp_res = awaited_results.pop_front();
                    if (m_axis_tdata !== exp_res.item || m_axis_tuser !== exp_res.status
                        || m_axis_tlast !== exp_res.last)
                    begin
                        $display("%0t: mismatch, expected item %0d status %0d last %0d, got item %0d status %0d last %0d",
                                 $time, $signed(exp_res.item), exp_res.status, exp_res.last,
                                 $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_deque_op(s_axis_tuser, s_axis_tdata);
            pending <= awaited_results.size();
        end
    end

endmodule

// File: sim/tb_double_ended_queue.sv
// testbench top for the double-ended queue: stimulus, receiver stalls and verdict
module tb_double_ended_queue;

    import dq_pkg::*;

    localparam int DEPTH = 32;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;
    localparam int FILL_ITEMS  = 45;
    localparam int DRAIN_ITEMS = 25;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic signed [VALUE_W-1:0] s_axis_tdata = '0;   // value
    logic [ACTION_W-1:0]       s_axis_tuser = '0;   // action
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic signed [VALUE_W-1:0] m_axis_tdata;        // item
    logic [STATUS_W-1:0]       m_axis_tuser;        // status
    logic                      m_axis_tlast;

    int errors;
    int pending;
    int burst_left = 0;
    int rx_cycle = 0;

    double_ended_queue #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    dq_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // receiver stall pattern steps through always ready, random, periodic and mostly ready
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 97) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(1, 0) == 1);
            2: m_axis_tready <= (rx_cycle % 4 == 0);
            default: m_axis_tready <= ($urandom_range(9, 0) < 8);
        endcase
    end

    task automatic send_op(input logic [ACTION_W-1:0] action,
                           input logic signed [VALUE_W-1:0] value);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(12, 0);
            gap = $urandom_range(5, 0);
            // a zero gap keeps valid high into the next transaction
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(7, 0))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_phase(input bit filling, input int count);
        int roll;
        logic [ACTION_W-1:0] op;
        repeat (count)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 2)
                op = ACTION_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
            else if (roll < 10)
                op = ACT_LIST;
            else if ((roll < 95) == filling)
                op = ($urandom_range(1, 0) == 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
            else
                op = ($urandom_range(1, 0) == 1) ? ACT_POP_FRONT : ACT_POP_BACK;
            send_op(op, pick_value());
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corner cases
        send_op(ACT_LIST, 32'sd0);
        send_op(ACT_POP_FRONT, 32'sd0);
        send_op(ACT_POP_BACK, 32'sd0);
        // front insert from index zero wraps the ring
        send_op(ACT_PUSH_FRONT, 32'sh7fff_ffff);
        send_op(ACT_PUSH_BACK, 32'sh8000_0000);
        send_op(ACT_PUSH_FRONT, 32'sd0);
        send_op(ACT_PUSH_BACK, -32'sd1);
        send_op(ACT_LIST, 32'sd0);
        send_op(ACT_UNUSED_LO, 32'sh1234_5678);
        send_op(ACT_UNUSED_LO + 3'd1, -32'sd1);
        send_op(ACT_UNUSED_HI, 32'sd0);
        send_op(ACT_POP_FRONT, 32'sd0);
        send_op(ACT_POP_BACK, -32'sd1);
        send_op(ACT_LIST, 32'sd0);
        send_op(ACT_PUSH_BACK, 32'sh5555_5555);
        send_op(ACT_PUSH_FRONT, 32'shaaaa_aaaa);
        send_op(ACT_LIST, -32'sd1);
        send_op(ACT_POP_BACK, 32'sd0);
        send_op(ACT_POP_FRONT, 32'sd0);
        send_op(ACT_POP_FRONT, 32'sd0);
        send_op(ACT_LIST, 32'sd0);

        // fill to full, then drain most of it, twice
        random_phase(1'b1, FILL_ITEMS);
        random_phase(1'b0, DRAIN_ITEMS);
        wait_drained();
        random_phase(1'b1, FILL_ITEMS);
        random_phase(1'b0, DRAIN_ITEMS);

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule
